>>> rtl/core/ssra_pkg.sv
package ssra_pkg;

    localparam int NUM_SLOTS   = 4096;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int REF_W       = 8;
    localparam int ROW_BITS    = 64;
    localparam int BIT_W       = $clog2(ROW_BITS);
    localparam int ROW_W       = SLOT_W - BIT_W;
    localparam int NUM_ROWS    = NUM_SLOTS / ROW_BITS;
    localparam int STATUS_W    = 3;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Reset value of the slots_in_use register.
    localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(4096);

    // n / 10 == (n * 3277) >> 15 holds exactly for every 13-bit n.
    localparam int DIV10_MUL   = 3277;
    localparam int DIV10_MUL_W = 12;
    localparam int DIV10_SHIFT = 15;

    // Release results at or above this count are rejected.
    localparam logic [REF_W-1:0] REF_TOO_HIGH = REF_W'(254);
    localparam logic [REF_W-1:0] REF_MAX      = '1;

    localparam logic REG_SLOTS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_DUP     = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOFREE    = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_RANGE     = 3'd4
    } res_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EXEC,
        S_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic idle;
        logic accept;
        logic load;
        logic scan_chk;
        logic exec;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic free_zero;
        logic out_of_range;
        logic scan_hit;
        logic scan_more;
        logic out_free;
    } dp_sts_t;

endpackage

>>> rtl/core/ssra_ram.sv
module ssra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/ssra_ctrl.sv
module ssra_ctrl
    import ssra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.is_alloc)
                begin
                    state_next = sts.free_zero ? S_FIN : S_SCAN_CHK;
                end
                else
                begin
                    state_next = sts.out_of_range ? S_FIN : S_EXEC;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                priority if (sts.scan_hit)
                begin
                    state_next = S_FIN;
                end
                else if (sts.scan_more)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            S_IDLE:
            begin
                cmd.idle   = 1'b1;
                cmd.accept = in_valid;
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
            end
            S_SCAN_RD:
            begin
                cmd = '0;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_FIN:
            begin
                cmd.fin = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> ($past(state_reg) == S_LOAD))
        else $error("execute state not entered from load");

    a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> sts.out_free)
        else $error("result written while output register is occupied");

endmodule

>>> rtl/core/ssra_dp.sv
module ssra_dp
    import ssra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_sts_t             sts,
    input  logic [1:0]          opcode,
    input  logic [SLOT_W-1:0]   slot,
    input  logic                out_stall,
    input  logic                cfg_wr,
    input  logic [CNT_W-1:0]    cfg_limit,
    input  logic [CNT_W-1:0]    limit,
    input  logic [CNT_W-1:0]    limit_div10,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [REF_W-1:0]    ref_count,
    output logic [CNT_W-1:0]    free_slots,
    output logic                nearly_full
);

    op_t                op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [SLOT_W-1:0]  hint_reg;
    logic [SLOT_W-1:0]  hint_next;
    logic [CNT_W-1:0]   free_count_reg;
    logic [CNT_W-1:0]   free_count_next;
    logic [SLOT_W-1:0]  clr_reg;

    res_status_t        res_status_reg;
    res_status_t        res_status_next;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [SLOT_W-1:0]  res_slot_next;
    logic [REF_W-1:0]   res_cnt_reg;
    logic [REF_W-1:0]   res_cnt_next;

    logic                out_valid_reg;
    res_status_t         out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [REF_W-1:0]    out_cnt_reg;
    logic [CNT_W-1:0]    out_free_reg;
    logic                out_near_reg;

    // Count memory and the free map: one bit per slot, set while its count is zero.
    logic                cnt_we;
    logic [SLOT_W-1:0]   cnt_waddr;
    logic [REF_W-1:0]    cnt_wdata;
    logic [REF_W-1:0]    cnt_rdata;
    logic                bmp_we;
    logic [ROW_W-1:0]    bmp_waddr;
    logic [ROW_BITS-1:0] bmp_wdata;
    logic [ROW_W-1:0]    bmp_raddr;
    logic [ROW_BITS-1:0] bmp_rdata;

    logic [ROW_BITS-1:0] lo_mask;
    logic [ROW_BITS-1:0] hi_mask;
    logic [ROW_BITS-1:0] cand;
    logic [BIT_W-1:0]    hit_bit;
    logic [SLOT_W-1:0]   hit_idx;
    logic [ROW_W:0]      row_inc;
    logic [ROW_W:0]      row_ext;
    logic [ROW_W:0]      limit_row;
    logic [BIT_W-1:0]    limit_bit;

    logic [REF_W-1:0]    cnt_dec;
    logic [REF_W-1:0]    cnt_inc;
    logic [ROW_BITS-1:0] slot_onehot;
    logic                rel_ok;
    logic                rel_zero;
    logic                dup_ok;

    ssra_ram #(
        .WIDTH (REF_W),
        .DEPTH (NUM_SLOTS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (slot_reg),
        .rdata (cnt_rdata)
    );

    ssra_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_ROWS)
    ) u_bmp_ram (
        .clk   (clk),
        .we    (bmp_we),
        .waddr (bmp_waddr),
        .wdata (bmp_wdata),
        .raddr (bmp_raddr),
        .rdata (bmp_rdata)
    );

    // Allocate reads the hint row at load, then row_reg; others read the slot's row.
    always_comb
    begin
        if (op_reg == OP_ALLOC)
        begin
            bmp_raddr = cmd.load ? hint_reg[SLOT_W-1:BIT_W] : row_reg;
        end
        else
        begin
            bmp_raddr = slot_reg[SLOT_W-1:BIT_W];
        end
    end

    // Candidate bits of the row: at or above the hint and below the limit.
    assign limit_row = limit[CNT_W-1:BIT_W];
    assign limit_bit = limit[BIT_W-1:0];
    assign row_ext   = {1'b0, row_reg};
    assign row_inc   = row_ext + (ROW_W+1)'(1);

    always_comb
    begin
        if (row_reg == hint_reg[SLOT_W-1:BIT_W])
        begin
            lo_mask = ~((ROW_BITS'(1) << hint_reg[BIT_W-1:0]) - ROW_BITS'(1));
        end
        else
        begin
            lo_mask = '1;
        end

        priority if (row_ext < limit_row)
        begin
            hi_mask = '1;
        end
        else if (row_ext == limit_row)
        begin
            hi_mask = (ROW_BITS'(1) << limit_bit) - ROW_BITS'(1);
        end
        else
        begin
            hi_mask = '0;
        end
    end

    assign cand = bmp_rdata & lo_mask & hi_mask;

    always_comb
    begin
        hit_bit = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign hit_idx = {row_reg, hit_bit};

    assign cnt_dec     = cnt_rdata - REF_W'(1);
    assign cnt_inc     = cnt_rdata + REF_W'(1);
    assign slot_onehot = ROW_BITS'(1) << slot_reg[BIT_W-1:0];
    assign rel_ok      = (op_reg == OP_RELEASE) && (cnt_dec < REF_TOO_HIGH);
    assign rel_zero    = rel_ok && (cnt_dec == '0);
    assign dup_ok      = (op_reg == OP_DUP) && (cnt_rdata != REF_MAX);

    assign sts.clr_last     = (clr_reg == SLOT_W'(NUM_SLOTS - 1));
    assign sts.is_alloc     = (op_reg == OP_ALLOC);
    assign sts.free_zero    = (free_count_reg == '0);
    assign sts.out_of_range = ({1'b0, slot_reg} >= limit);
    assign sts.scan_hit     = |cand;
    assign sts.scan_more    = ({row_inc, BIT_W'(0)} < limit);
    assign sts.out_free     = !out_valid_reg || !out_stall;

    // Memory writes.
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = slot_reg;
        cnt_wdata = '0;
        bmp_we    = 1'b0;
        bmp_waddr = slot_reg[SLOT_W-1:BIT_W];
        bmp_wdata = bmp_rdata;
        priority if (cmd.clear)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_reg;
            bmp_we    = 1'b1;
            bmp_waddr = clr_reg[ROW_W-1:0];
            bmp_wdata = '1;
        end
        else if (cmd.scan_chk && sts.scan_hit)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = hit_idx;
            cnt_wdata = REF_W'(1);
            bmp_we    = 1'b1;
            bmp_waddr = row_reg;
            bmp_wdata = bmp_rdata & ~(ROW_BITS'(1) << hit_bit);
        end
        else if (cmd.exec && rel_ok)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_dec;
            bmp_we    = rel_zero;
            bmp_wdata = bmp_rdata | slot_onehot;
        end
        else if (cmd.exec && dup_ok)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_inc;
            bmp_we    = (cnt_rdata == '0);
            bmp_wdata = bmp_rdata & ~slot_onehot;
        end
        else
        begin
            cnt_we = 1'b0;
        end
    end

    // Allocator state and the pending result.
    always_comb
    begin
        row_next        = row_reg;
        hint_next       = hint_reg;
        free_count_next = free_count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_cnt_next    = res_cnt_reg;

        if (cmd.load)
        begin
            row_next     = hint_reg[SLOT_W-1:BIT_W];
            res_cnt_next = '0;
            if (op_reg == OP_ALLOC)
            begin
                // Stays unless the scan finds a free slot.
                res_status_next = ST_NOFREE;
                res_slot_next   = '0;
            end
            else
            begin
                res_status_next = ST_RANGE;
                res_slot_next   = slot_reg;
            end
        end

        if (cmd.scan_chk)
        begin
            if (sts.scan_hit)
            begin
                hint_next       = hit_idx;
                free_count_next = free_count_reg - CNT_W'(1);
                res_status_next = ST_OK;
                res_slot_next   = hit_idx;
                res_cnt_next    = REF_W'(1);
            end
            else
            begin
                row_next = row_inc[ROW_W-1:0];
            end
        end

        if (cmd.exec)
        begin
            res_status_next = ST_OK;
            unique case (op_reg)
                OP_RELEASE:
                begin
                    if (rel_ok)
                    begin
                        res_cnt_next = cnt_dec;
                        if (rel_zero)
                        begin
                            if (free_count_reg < limit)
                            begin
                                free_count_next = free_count_reg + CNT_W'(1);
                            end
                            if (slot_reg < hint_reg)
                            begin
                                hint_next = slot_reg;
                            end
                        end
                    end
                    else
                    begin
                        res_status_next = ST_UNDERFLOW;
                        res_cnt_next    = cnt_rdata;
                    end
                end
                OP_DUP:
                begin
                    if (dup_ok)
                    begin
                        res_cnt_next = cnt_inc;
                    end
                    else
                    begin
                        res_status_next = ST_OVERFLOW;
                        res_cnt_next    = REF_MAX;
                    end
                end
                OP_QUERY:
                begin
                    res_cnt_next = cnt_rdata;
                end
                OP_ALLOC:
                begin
                    res_cnt_next = res_cnt_reg;
                end
                default:
                begin
                    res_cnt_next = res_cnt_reg;
                end
            endcase
        end

        if (cfg_wr)
        begin
            free_count_next = cfg_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg       <= '0;
            free_count_reg <= SLOTS_RESET;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hint_reg       <= hint_next;
            free_count_reg <= free_count_next;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= op_t'(opcode);
            slot_reg <= slot;
        end
        row_reg        <= row_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_cnt_reg    <= res_cnt_next;
        if (cmd.fin)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_cnt_reg    <= res_cnt_reg;
            out_free_reg   <= free_count_reg;
            out_near_reg   <= (free_count_reg < limit_div10);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_out    = out_slot_reg;
    assign ref_count   = out_cnt_reg;
    assign free_slots  = out_free_reg;
    assign nearly_full = out_near_reg;

    a_free_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= limit)
        else $error("free count exceeds usable limit");

    a_grant_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_chk && sts.scan_hit) |->
            (({1'b0, hit_idx} < limit) && (hit_idx >= hint_reg)))
        else $error("granted slot outside hint and limit window");

endmodule

>>> rtl/core/swap_slot_refcount_allocator.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | opcode, slot
// out     | output    | out_valid/out_stall | status, slot_out, ref_count, free_slots,
//         |           |                     | nearly_full
// config  | input     | APB write/read      | slots_in_use at byte address 0
//
// Release, duplicate and query pass through accept, memory read, update and result; an
// out-of-range slot skips the update. Allocate checks the hint's row of 64 slots, then reads
// and checks each further row of the free map until a slot is found or the limit is passed,
// and goes straight to the result at zero free. After reset a clearing pass sweeps the count
// memory and holds off input; configuration writes are taken throughout. A stalled result
// stays in the output register; the next transaction runs up to its result and waits there.
module swap_slot_refcount_allocator
    import ssra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          opcode,
    input  logic [SLOT_W-1:0]   slot,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [REF_W-1:0]    ref_count,
    output logic [CNT_W-1:0]    free_slots,
    output logic                nearly_full,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    logic [CNT_W-1:0]             slots_in_use_reg;
    logic [CNT_W-1:0]             limit;
    logic [CNT_W-1:0]             limit_div10_reg;
    logic [CNT_W+DIV10_MUL_W-1:0] div10_prod;
    logic [CNT_W-1:0]             wr_value;
    logic [CNT_W-1:0]             cfg_limit;
    logic                         cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE);
    assign wr_value = pwdata[CNT_W-1:0];

    assign cfg_limit = (wr_value < CNT_W'(NUM_SLOTS)) ? wr_value : CNT_W'(NUM_SLOTS);
    assign limit     = (slots_in_use_reg < CNT_W'(NUM_SLOTS)) ?
                       slots_in_use_reg : CNT_W'(NUM_SLOTS);

    assign div10_prod = (CNT_W+DIV10_MUL_W)'(limit) *
                        (CNT_W+DIV10_MUL_W)'(DIV10_MUL);

    always_comb
    begin
        if (paddr[2] == REG_SLOTS_IN_USE)
        begin
            prdata = APB_DW'(slots_in_use_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_RESET;
            limit_div10_reg  <= CNT_W'(NUM_SLOTS / 10);
        end
        else
        begin
            if (cfg_wr)
            begin
                slots_in_use_reg <= wr_value;
            end
            limit_div10_reg <= CNT_W'(div10_prod >> DIV10_SHIFT);
        end
    end

    assign in_stall = !cmd.idle;

    ssra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssra_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (opcode),
        .slot        (slot),
        .out_stall   (out_stall),
        .cfg_wr      (cfg_wr),
        .cfg_limit   (cfg_limit),
        .limit       (limit),
        .limit_div10 (limit_div10_reg),
        .out_valid   (out_valid),
        .status      (status),
        .slot_out    (slot_out),
        .ref_count   (ref_count),
        .free_slots  (free_slots),
        .nearly_full (nearly_full)
    );

endmodule

>>> bench/swap_slot_refcount_allocator_test.sv
module swap_slot_refcount_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssra_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 16;

    typedef struct packed {
        res_status_t        st;
        logic [SLOT_W-1:0]  slot;
        logic [REF_W-1:0]   cnt;
        logic [CNT_W-1:0]   free;
        logic               nf;
    } slot_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        int unsigned        cfg;
        bit                 typed;
        slot_result_t       want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          opcode;
    logic [SLOT_W-1:0]   slot;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [REF_W-1:0]    ref_count;
    logic [CNT_W-1:0]    free_slots;
    logic                nearly_full;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Allocator shadow state, advanced once per accepted transaction and config write.
    logic [REF_W-1:0] shadow_counts [NUM_SLOTS];
    int unsigned      shadow_hint;
    int unsigned      shadow_free;
    int unsigned      shadow_slots_cfg;

    slot_result_t     awaited_results [$];
    slot_result_t     last_result;
    slot_result_t     oldest_result;
    stim_row_t        stim_table [$];
    int               error_count = 0;
    int unsigned      cycle_count = 0;
    int               stall_hold = 0;
    bit               calm = 0;

    swap_slot_refcount_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .slot        (slot),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_out    (slot_out),
        .ref_count   (ref_count),
        .free_slots  (free_slots),
        .nearly_full (nearly_full),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned usable_slots();
        return (shadow_slots_cfg < NUM_SLOTS) ? shadow_slots_cfg : NUM_SLOTS;
    endfunction

    function automatic slot_result_t predict_slot_op(input op_t op, input logic [SLOT_W-1:0] s);
        slot_result_t r;
        int unsigned  lim;
        int unsigned  idx;
        int unsigned  nv;
        bit           found;
        lim = usable_slots();
        found = 1'b0;
        r.st = ST_OK;
        r.slot = s;
        r.cnt = '0;
        if (op == OP_ALLOC)
        begin
            r.slot = '0;
            if (shadow_free != 0)
            begin
                for (idx = shadow_hint; idx < lim; idx++)
                begin
                    if (shadow_counts[idx] == 0)
                    begin
                        found = 1'b1;
                        break;
                    end
                end
                if (found)
                begin
                    shadow_counts[idx] = REF_W'(1);
                    shadow_hint = idx;
                    shadow_free--;
                    r.slot = SLOT_W'(idx);
                    r.cnt = REF_W'(1);
                end
            end
            if (!found)
                r.st = ST_NOFREE;
        end
        else if (s >= lim)
        begin
            r.st = ST_RANGE;
        end
        else if (op == OP_RELEASE)
        begin
            // A count of zero wraps to 255 here, so it lands in the rejected band too.
            nv = (shadow_counts[s] - 1) & 8'hFF;
            if (nv >= REF_TOO_HIGH)
            begin
                r.st = ST_UNDERFLOW;
                r.cnt = shadow_counts[s];
            end
            else
            begin
                shadow_counts[s] = REF_W'(nv);
                r.cnt = REF_W'(nv);
                if (nv == 0)
                begin
                    if (shadow_free < lim)
                        shadow_free++;
                    if (s < shadow_hint)
                        shadow_hint = s;
                end
            end
        end
        else if (op == OP_DUP)
        begin
            if (shadow_counts[s] == REF_MAX)
            begin
                r.st = ST_OVERFLOW;
                r.cnt = REF_MAX;
            end
            else
            begin
                shadow_counts[s] = shadow_counts[s] + 1'b1;
                r.cnt = shadow_counts[s];
            end
        end
        else
        begin
            r.cnt = shadow_counts[s];
        end
        r.free = CNT_W'(shadow_free);
        r.nf = (shadow_free < lim / 10);
        return r;
    endfunction

    // Most gaps are short, a few are long; calm stretches have none.
    function automatic int idle_span();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 48);
    endfunction

    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(0, 99) < 40);
            stall_hold <= idle_span();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_error($sformatf("result for slot %0d with no transaction pending",
                                     slot_out));
            end
            else
            begin
                oldest_result = awaited_results.pop_front();
                if (status !== oldest_result.st)
                    flag_error($sformatf("status got %0d want %0d",
                                         status, oldest_result.st));
                if (slot_out !== oldest_result.slot)
                    flag_error($sformatf("slot_out got %0d want %0d",
                                         slot_out, oldest_result.slot));
                if (ref_count !== oldest_result.cnt)
                    flag_error($sformatf("ref_count got %0d want %0d (slot %0d)",
                                         ref_count, oldest_result.cnt, oldest_result.slot));
                if (free_slots !== oldest_result.free)
                    flag_error($sformatf("free_slots got %0d want %0d",
                                         free_slots, oldest_result.free));
                if (nearly_full !== oldest_result.nf)
                    flag_error($sformatf("nearly_full got %0d want %0d",
                                         nearly_full, oldest_result.nf));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("swap_slot_refcount_allocator_test NOT OK");
            $finish;
        end
    end

    task automatic send_op(input op_t op, input logic [SLOT_W-1:0] s, input bit typed,
                           input slot_result_t want);
        int           gap;
        slot_result_t pred;
        gap = idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        slot <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_slot_op(op, s);
        last_result = pred;
        awaited_results.push_back(typed ? want : pred);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes slots_in_use and reads it back in the following APB transfer.
    task automatic write_slots_in_use(input int unsigned v);
        paddr <= APB_AW'(4 * REG_SLOTS_IN_USE);
        pwdata <= APB_DW'(v);
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        shadow_slots_cfg = v & 32'h1FFF;
        shadow_free = usable_slots();
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== APB_DW'(shadow_slots_cfg))
            flag_error($sformatf("slots_in_use read back %0d want %0d",
                                 prdata, shadow_slots_cfg));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_item(input op_t op, input int s);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.op = op;
        row.slot = SLOT_W'(s);
        row.cfg = 0;
        row.typed = 1'b0;
        row.want = '0;
        stim_table.push_back(row);
    endtask

    task automatic add_known(input op_t op, input int s, input res_status_t st, input int so,
                             input int c, input int f, input bit nf);
        stim_row_t row;
        row.kind = ROW_ITEM;
        row.op = op;
        row.slot = SLOT_W'(s);
        row.cfg = 0;
        row.typed = 1'b1;
        row.want.st = st;
        row.want.slot = SLOT_W'(so);
        row.want.cnt = REF_W'(c);
        row.want.free = CNT_W'(f);
        row.want.nf = nf;
        stim_table.push_back(row);
    endtask

    task automatic add_cfg(input int unsigned v);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.op = OP_QUERY;
        row.slot = '0;
        row.cfg = v;
        row.typed = 1'b0;
        row.want = '0;
        stim_table.push_back(row);
    endtask

    initial
    begin
        int unsigned       plan [6];
        int                n_items;
        int                r;
        int                k;
        op_t               op;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] burst_slot;
        logic [SLOT_W-1:0] granted [$];

        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_QUERY;
        slot = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        foreach (shadow_counts[i])
            shadow_counts[i] = '0;
        shadow_hint = 0;
        shadow_slots_cfg = SLOTS_RESET;
        shadow_free = usable_slots();

        // Fresh map with every slot usable.
        add_known(OP_QUERY,   0,     ST_OK,        0,    0, 4096, 0);
        add_known(OP_QUERY,   4095,  ST_OK,        4095, 0, 4096, 0);
        add_known(OP_RELEASE, 5,     ST_UNDERFLOW, 5,    0, 4096, 0);
        add_known(OP_ALLOC,   4095,  ST_OK,        0,    1, 4095, 0);
        add_known(OP_ALLOC,   0,     ST_OK,        1,    1, 4094, 0);
        add_known(OP_DUP,     0,     ST_OK,        0,    2, 4094, 0);
        add_known(OP_RELEASE, 0,     ST_OK,        0,    1, 4094, 0);
        add_known(OP_RELEASE, 0,     ST_OK,        0,    0, 4095, 0);
        add_known(OP_ALLOC,   0,     ST_OK,        0,    1, 4094, 0);
        add_known(OP_ALLOC,   0,     ST_OK,        2,    1, 4093, 0);
        add_known(OP_DUP,     4095,  ST_OK,        4095, 1, 4093, 0);
        // Three usable slots, all taken while the free count claims three.
        add_cfg(3);
        add_known(OP_ALLOC,   0,     ST_NOFREE,    0,    0, 3,    0);
        add_known(OP_QUERY,   3,     ST_RANGE,     3,    0, 3,    0);
        add_known(OP_RELEASE, 4095,  ST_RANGE,     4095, 0, 3,    0);
        add_known(OP_RELEASE, 1,     ST_OK,        1,    0, 3,    0);
        add_known(OP_ALLOC,   0,     ST_OK,        1,    1, 2,    0);
        add_item(OP_DUP, 2);
        // No usable slots at all.
        add_cfg(0);
        add_known(OP_ALLOC,   0,     ST_NOFREE,    0,    0, 0,    0);
        add_known(OP_DUP,     0,     ST_RANGE,     0,    0, 0,    0);
        add_known(OP_QUERY,   4095,  ST_RANGE,     4095, 0, 0,    0);
        add_cfg(4096);
        add_known(OP_RELEASE, 0,     ST_OK,        0,    0, 4096, 0);
        add_item(OP_DUP, 12'hAAA);
        add_item(OP_DUP, 12'h555);
        add_item(OP_RELEASE, 12'h555);
        add_item(OP_ALLOC, 12'hFFF);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
            begin
                settle();
                write_slots_in_use(stim_table[i].cfg);
            end
            else
            begin
                send_op(stim_table[i].op, stim_table[i].slot, stim_table[i].typed,
                        stim_table[i].want);
            end
        end

        plan = '{4096, 64, 10, 0, 300, 4096};
        foreach (plan[p])
        begin
            settle();
            write_slots_in_use(plan[p]);
            if (p == 0)
            begin
                // Drive one slot's count to the top, past it, then release from there.
                send_op(OP_ALLOC, '0, 1'b0, '0);
                burst_slot = last_result.slot;
                granted.push_back(burst_slot);
                repeat (256) send_op(OP_DUP, burst_slot, 1'b0, '0);
                send_op(OP_RELEASE, burst_slot, 1'b0, '0);
                send_op(OP_QUERY, burst_slot, 1'b0, '0);
            end
            n_items = (plan[p] == 0) ? 20 : 40;
            for (int n = 0; n < n_items; n++)
            begin
                if (n % 25 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    op = OP_ALLOC;
                    s = SLOT_W'($urandom);
                end
                else if (r < 85 && granted.size() > 0)
                begin
                    k = $urandom_range(0, granted.size() - 1);
                    s = granted[k];
                    if (shadow_counts[s] == 0)
                        granted.delete(k);
                    case ($urandom_range(0, 3))
                        0, 1: op = OP_RELEASE;
                        2: op = OP_DUP;
                        default: op = OP_QUERY;
                    endcase
                end
                else
                begin
                    op = op_t'($urandom_range(0, 3));
                    s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                end
                send_op(op, s, 1'b0, '0);
                if (op == OP_ALLOC && last_result.st == ST_OK)
                    granted.push_back(last_result.slot);
            end
        end

        settle();
        if (error_count == 0)
            $display("swap_slot_refcount_allocator_test OK");
        else
            $display("swap_slot_refcount_allocator_test NOT OK");
        $finish;
    end

endmodule
